### hdl/hxb_pkg.sv
`timescale 1ns / 1ps

package hxb_pkg;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_X = 8'h78;
	localparam logic [7:0] CHAR_UPPER_X = 8'h58;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0d;
	localparam logic [3:0] LETTER_BASE  = 4'd10;

	typedef enum logic [1:0] {
		POS_OPEN   = 2'd0,
		POS_HELD   = 2'd1,
		POS_CLOSED = 2'd2
	} hxb_pos_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CHAR  = 2'd1,
		ST_NO_DIGITS = 2'd2,
		ST_ODD_COUNT = 2'd3
	} hxb_status_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} hxb_in_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       byte_present;
		logic       string_end;
		logic [1:0] status;
	} hxb_out_t;

	typedef struct packed {
		logic       space;
		logic       hex;
		logic       zero;
		logic       x_mark;
		logic [3:0] nibble;
	} hxb_class_t;

	typedef struct packed {
		hxb_pos_t   pos;
		logic [3:0] pend;
		logic       held;
		logic       digit_seen;
		logic       bad;
		logic       first_zero;
	} hxb_state_t;

	typedef struct packed {
		logic     emit;
		hxb_out_t data;
	} hxb_res_t;

endpackage

### hdl/hex_text_to_bytes_core.sv
`timescale 1ns / 1ps

// Streaming hex text decoder: takes one character per transfer, one transfer per cycle
// sustained, and returns each result through an input register, then a result
// register; only out_ready holding off a pending result slows intake. A result
// appears for each completed byte and for the last character of a string, which
// carries the status (ok, bad character, no digits, odd digit count). Bytes of a
// failed string that went out before the error must be discarded downstream.
// cfg_wdata sets whether leading whitespace may come before a 0x prefix; write it
// only while the block is idle.
module hex_text_to_bytes_core
	import hxb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hxb_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output hxb_out_t out_data,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);

	logic     prefix_after_space_q;
	logic     valid_s1;
	hxb_in_t  item_s1;
	hxb_res_t res;
	logic     go;
	logic     out_valid_q;
	hxb_out_t out_data_q;

	hxb_step u_step (
		.clk                (clk),
		.arst_n             (arst_n),
		.prefix_after_space (prefix_after_space_q),
		.take               (go),
		.item               (item_s1),
		.res                (res)
	);

	assign go        = valid_s1 && (!res.emit || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || go;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_after_space_q <= 1'b0;
		end else if (cfg_we) begin
			prefix_after_space_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res.emit) begin
			out_data_q <= res.data;
		end
	end

endmodule

### hdl/hxb_classify.sv
`timescale 1ns / 1ps

module hxb_classify
	import hxb_pkg::*;
(
	input  logic [7:0] char_code,
	output hxb_class_t cls
);

	logic is_dec;
	logic is_low;
	logic is_up;
	logic [7:0] dec_off;
	logic [7:0] low_off;
	logic [7:0] up_off;

	always_comb begin
		is_dec  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
		is_low  = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
		is_up   = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);
		dec_off = char_code - CHAR_ZERO;
		low_off = char_code - CHAR_LOWER_A;
		up_off  = char_code - CHAR_UPPER_A;

		cls.space  = (char_code == CHAR_SPACE) ||
			((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
		cls.hex    = is_dec || is_low || is_up;
		cls.zero   = (char_code == CHAR_ZERO);
		cls.x_mark = (char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X);
		if (is_dec) begin
			cls.nibble = dec_off[3:0];
		end else if (is_low) begin
			cls.nibble = low_off[3:0] + LETTER_BASE;
		end else begin
			cls.nibble = up_off[3:0] + LETTER_BASE;
		end
	end

endmodule

### hdl/hxb_step.sv
`timescale 1ns / 1ps

module hxb_step
	import hxb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       prefix_after_space,
	input  logic       take,
	input  hxb_in_t    item,
	output hxb_res_t   res
);

	typedef struct packed {
		hxb_state_t st;
		logic       have;
		logic [7:0] data_b;
	} hxb_feed_t;

	hxb_state_t state_q;
	hxb_state_t state_d;
	hxb_class_t cls;

	hxb_classify u_classify (
		.char_code (item.char_code),
		.cls       (cls)
	);

	function automatic hxb_feed_t feed(input hxb_feed_t f, input logic [3:0] v);
		hxb_feed_t r;
		r = f;
		r.st.digit_seen = 1'b1;
		if (f.st.held) begin
			r.data_b  = {f.st.pend, v};
			r.have    = 1'b1;
			r.st.held = 1'b0;
			r.st.pend = 4'd0;
		end else begin
			r.st.pend = v;
			r.st.held = 1'b1;
		end
		return r;
	endfunction

	function automatic hxb_feed_t plain(input hxb_feed_t f, input hxb_class_t c);
		hxb_feed_t r;
		r = f;
		if (!c.space) begin
			if (c.hex) begin
				r = feed(f, c.nibble);
			end else begin
				r.st.bad = 1'b1;
			end
		end
		return r;
	endfunction

	hxb_feed_t   f;
	hxb_status_t status;

	always_comb begin
		f.st     = state_q;
		f.have   = 1'b0;
		f.data_b = 8'd0;

		if (!state_q.bad) begin
			unique case (state_q.pos)
				POS_OPEN: begin
					if (cls.space) begin
						if (!prefix_after_space) begin
							f.st.pos = POS_CLOSED;
						end
					end else if (cls.zero) begin
						f.st.pos        = POS_HELD;
						f.st.first_zero = 1'b1;
					end else begin
						f.st.pos = POS_CLOSED;
						f        = plain(f, cls);
					end
				end
				POS_HELD: begin
					f.st.pos = POS_CLOSED;
					if (state_q.first_zero && cls.x_mark) begin
						f.st.first_zero = 1'b0;
					end else begin
						if (state_q.first_zero) begin
							f = feed(f, 4'd0);
						end
						f.st.first_zero = 1'b0;
						f = plain(f, cls);
					end
				end
				default: begin
					f = plain(f, cls);
				end
			endcase
		end

		// a lone leading zero at string end still counts as a digit
		if (item.last_char && !f.st.bad && (f.st.pos == POS_HELD) &&
				f.st.first_zero) begin
			f = feed(f, 4'd0);
		end

		if (f.st.bad) begin
			f.have = 1'b0;
		end

		priority if (f.st.bad) begin
			status = ST_BAD_CHAR;
		end else if (!f.st.digit_seen) begin
			status = ST_NO_DIGITS;
		end else if (f.st.held) begin
			status = ST_ODD_COUNT;
		end else begin
			status = ST_OK;
		end

		res.emit              = f.have || item.last_char;
		res.data.byte_value   = f.have ? f.data_b : 8'd0;
		res.data.byte_present = f.have;
		res.data.string_end   = item.last_char;
		res.data.status       = item.last_char ? status : ST_OK;

		state_d = f.st;
		if (item.last_char) begin
			state_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			state_q <= state_d;
		end
	end

endmodule

### tb/hex_text_to_bytes_core_test.sv
`timescale 1ns / 1ps

module hex_text_to_bytes_core_test;
	import hxb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASE_CHARS = 335;

	class byte_scoreboard;
		bit space_before_prefix;
		hxb_pos_t pos;
		logic [3:0] pend;
		bit held;
		bit digit_seen;
		bit bad;
		bit first_zero;
		bit have;
		logic [7:0] value;
		hxb_out_t expected_q[$];
		int mismatches;
		int checked;

		function new();
			space_before_prefix = 0;
			mismatches = 0;
			checked = 0;
			clear_string();
		endfunction

		static function bit is_blank(logic [7:0] c);
			return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
		endfunction

		static function int nibble_of(logic [7:0] c);
			if (c >= CHAR_ZERO && c <= CHAR_NINE)
				return c - CHAR_ZERO;
			if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
				return c - CHAR_LOWER_A + LETTER_BASE;
			if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
				return c - CHAR_UPPER_A + LETTER_BASE;
			return -1;
		endfunction

		function void clear_string();
			pos = POS_OPEN;
			pend = '0;
			held = 0;
			digit_seen = 0;
			bad = 0;
			first_zero = 0;
		endfunction

		function void take_nibble(logic [3:0] v);
			digit_seen = 1;
			if (held) begin
				value = {pend, v};
				have = 1;
				held = 0;
				pend = '0;
			end else begin
				pend = v;
				held = 1;
			end
		endfunction

		function void plain_char(logic [7:0] c);
			int v;
			if (is_blank(c))
				return;
			v = nibble_of(c);
			if (v < 0) begin
				bad = 1;
				return;
			end
			take_nibble(v[3:0]);
		endfunction

		function void note_char(hxb_in_t item);
			hxb_status_t st;
			hxb_out_t res;
			logic [7:0] c;
			c = item.char_code;
			have = 0;
			value = '0;
			if (!bad) begin
				unique case (pos)
					POS_HELD: begin
						pos = POS_CLOSED;
						if (first_zero && (c == CHAR_LOWER_X || c == CHAR_UPPER_X)) begin
							first_zero = 0;
						end else begin
							if (first_zero)
								take_nibble(4'd0);
							first_zero = 0;
							plain_char(c);
						end
					end
					POS_OPEN: begin
						if (is_blank(c)) begin
							if (!space_before_prefix)
								pos = POS_CLOSED;
						end else if (c == CHAR_ZERO) begin
							pos = POS_HELD;
							first_zero = 1;
						end else begin
							pos = POS_CLOSED;
							plain_char(c);
						end
					end
					default: plain_char(c);
				endcase
			end
			if (bad)
				have = 0;
			if (!item.last_char) begin
				if (have) begin
					res.byte_value = value;
					res.byte_present = 1'b1;
					res.string_end = 1'b0;
					res.status = ST_OK;
					expected_q = {expected_q, res};
				end
				return;
			end
			// a leading zero still held at the end counts as a digit
			if (!bad && pos == POS_HELD && first_zero)
				take_nibble(4'd0);
			if (bad)
				st = ST_BAD_CHAR;
			else if (!digit_seen)
				st = ST_NO_DIGITS;
			else if (held)
				st = ST_ODD_COUNT;
			else
				st = ST_OK;
			res.byte_value = have ? value : 8'd0;
			res.byte_present = have;
			res.string_end = 1'b1;
			res.status = st;
			expected_q = {expected_q, res};
			clear_string();
		endfunction

		function void check_result(hxb_out_t got);
			hxb_out_t want;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: byte %02h present %0b end %0b %0d",
						got.byte_value, got.byte_present, got.string_end, got.status);
				return;
			end
			want = expected_q.pop_front();
			if (got.byte_value !== want.byte_value || got.byte_present !== want.byte_present ||
					got.string_end !== want.string_end || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected byte %02h present %0b end %0b status %0d",
						want.byte_value, want.byte_present, want.string_end, want.status);
					$display("          got byte %02h present %0b end %0b status %0d",
						got.byte_value, got.byte_present, got.string_end, got.status);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	hxb_in_t in_data;
	logic out_valid;
	logic out_ready;
	hxb_out_t out_data;
	logic cfg_we;
	logic cfg_wdata;

	byte_scoreboard sb;
	logic [7:0] text_q[$];
	int chars_sent;
	int strings_sent;
	int burst_left;
	bit idle_enable;
	bit hold_request;
	int cycles;

	hex_text_to_bytes_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_char(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// receiver stall pattern
	initial begin
		int style;
		int left;
		int tick;
		style = 0;
		left = 0;
		tick = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 0;
			end else begin
				if (left == 0) begin
					style = $urandom_range(0, 3);
					left = $urandom_range(10, 60);
				end
				left--;
				tick++;
				unique case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < LETTER_BASE)
			return CHAR_ZERO + n;
		return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + (n - LETTER_BASE);
	endfunction

	function automatic logic [7:0] blank_char();
		logic [7:0] blanks[6];
		blanks = '{8'd9, 8'd10, 8'd11, 8'd12, CHAR_CR, CHAR_SPACE};
		return blanks[$urandom_range(0, 5)];
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (byte_scoreboard::is_blank(c) || byte_scoreboard::nibble_of(c) >= 0);
		return c;
	endfunction

	function automatic logic [7:0] random_hex_char();
		return hex_char(4'($urandom_range(0, 15)));
	endfunction

	task automatic offer_char(input logic [7:0] c, input logic last);
		int gap;
		if (idle_enable && burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 25);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		in_data <= '{char_code: c, last_char: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			offer_char(text_q[i], i == text_q.size() - 1);
		strings_sent++;
	endtask

	task automatic send_string(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q = {text_q, s[i]};
		send_text();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_prefix_mode(input bit mode);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.space_before_prefix = mode;
	endtask

	task automatic make_text();
		int kind;
		int n;
		int at;
		text_q.delete();
		kind = $urandom_range(0, 99);
		// pure noise
		if (kind < 10) begin
			n = $urandom_range(1, 8);
			repeat (n) text_q = {text_q, 8'($urandom_range(0, 255))};
			return;
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) text_q = {text_q, blank_char()};
		if ($urandom_range(0, 1)) begin
			text_q = {text_q, CHAR_ZERO};
			text_q = {text_q, ($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X)};
		end
		n = $urandom_range(0, 7);
		repeat (2 * n) begin
			text_q = {text_q, random_hex_char()};
			if ($urandom_range(0, 5) == 0)
				text_q = {text_q, blank_char()};
		end
		if (kind < 25) begin
			text_q = {text_q, random_hex_char()};
		end else if (kind < 40) begin
			at = $urandom_range(0, text_q.size());
			text_q.insert(at, junk_char());
		end
		if (text_q.size() == 0)
			text_q = {text_q, blank_char()};
	endtask

	initial begin
		int phase_start;
		sb = new();
		cycles = 0;
		chars_sent = 0;
		strings_sent = 0;
		burst_left = 0;
		idle_enable = 1;
		hold_request = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_prefix_mode(1'b0);
		send_string("0xAf");
		send_string("0X");
		send_string("0");
		send_string("09 ");
		text_q = '{8'hff};
		send_text();
		send_string(" 0x");
		text_q = '{8'h31, 8'h00};
		send_text();
		send_string("F\t");

		set_prefix_mode(1'b1);
		text_q = '{CHAR_SPACE, CHAR_CR, CHAR_ZERO, CHAR_LOWER_X, 8'h37, 8'h65};
		send_text();

		for (int phase = 0; phase < 4; phase++) begin
			set_prefix_mode(1'(phase % 2));
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS) begin
				idle_enable = ($urandom_range(0, 4) != 0);
				make_text();
				send_text();
			end
			if (phase == 1) begin
				// long receiver hold-off while the sender streams digits
				hold_request = 1;
				idle_enable = 0;
				text_q.delete();
				repeat (80) text_q = {text_q, random_hex_char()};
				send_text();
				idle_enable = 1;
				wait_drained();
			end
		end

		wait_drained();
		$display("covered %0d characters in %0d strings, %0d result transfers checked",
			chars_sent, strings_sent, sb.checked);
		$display("both prefix rules used, one receiver hold-off of %0d cycles", HOLD_CYCLES);
		if (sb.expected_q.size() != 0)
			$display("%0d expected results never arrived", sb.expected_q.size());
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/hxb_pkg.sv
hdl/hxb_classify.sv
hdl/hxb_step.sv
hdl/hex_text_to_bytes_core.sv
tb/hex_text_to_bytes_core_test.sv
